>>> hw/rtl/v3alu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package v3alu_pkg;

   localparam int FIELD_WIDTH = 32;
   localparam int OP_WIDTH    = 3;
   localparam int AXES        = 3;
   localparam int MUL_LANES   = 6;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD,
      OP_SUB,
      OP_SCALE,
      OP_DOT,
      OP_CROSS,
      OP_EQUAL,
      OP_LENGTH
   } op_type;

   typedef struct packed {
      logic        [OP_WIDTH-1:0]    req_type;
      logic signed [FIELD_WIDTH-1:0] a_x;
      logic signed [FIELD_WIDTH-1:0] a_y;
      logic signed [FIELD_WIDTH-1:0] a_z;
      logic signed [FIELD_WIDTH-1:0] b_x;
      logic signed [FIELD_WIDTH-1:0] b_y;
      logic signed [FIELD_WIDTH-1:0] b_z;
      logic signed [FIELD_WIDTH-1:0] scale_factor;
   } req_item_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] res_x;
      logic signed [FIELD_WIDTH-1:0] res_y;
      logic signed [FIELD_WIDTH-1:0] res_z;
      logic signed [FIELD_WIDTH-1:0] dot_value;
      logic        [FIELD_WIDTH-1:0] length_value;
      logic                          equal_flag;
      logic                          overflow_flag;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> hw/rtl/v3alu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module v3alu_front
   import v3alu_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_stall,
   input  wire req_item_type               in_data,
   output logic                            out_valid,
   input  wire logic                       out_stall,
   output rsp_item_type                    out_data,
   output logic [2*COORD_WIDTH-1:0]        out_radicand
);

   localparam int CW = COORD_WIDTH;
   localparam int SW = CW + 1;
   localparam int PW = 2 * CW;
   localparam int EW = 2 * CW + 1;

   typedef logic signed [CW-1:0] coord_type;

   function automatic logic fits(input logic signed [EW-1:0] v);
      logic [EW-CW:0] hi;
      hi = v[EW-1:CW-1];
      return (&hi) || !(|hi);
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] wrap(input logic [EW-1:0] v);
      return FIELD_WIDTH'($signed(v[CW-1:0]));
   endfunction

   logic s1_ready, s2_ready, s3_ready, s4_ready;

   coord_type        s1_a_in  [AXES];
   coord_type        s1_b_in  [AXES];
   coord_type        s1_f_in;
   coord_type        s1_ma_in [MUL_LANES];
   coord_type        s1_mb_in [MUL_LANES];
   op_type           s1_op_in;
   logic             s1_eq_in;

   logic             s1_valid_ff;
   op_type           s1_op_ff;
   logic             s1_eq_ff;
   coord_type        s1_a_ff  [AXES];
   coord_type        s1_b_ff  [AXES];
   coord_type        s1_ma_ff [MUL_LANES];
   coord_type        s1_mb_ff [MUL_LANES];

   logic signed [PW-1:0] s2_prod_in [MUL_LANES];
   logic signed [SW-1:0] s2_sum_in  [AXES];
   logic                 s2_valid_ff;
   op_type               s2_op_ff;
   logic                 s2_eq_ff;
   logic signed [PW-1:0] s2_prod_ff [MUL_LANES];
   logic signed [SW-1:0] s2_sum_ff  [AXES];

   logic signed [EW-1:0] s3_exact_in [AXES];
   logic signed [EW-1:0] s3_dot_in;
   logic                 s3_valid_ff;
   op_type               s3_op_ff;
   logic                 s3_eq_ff;
   logic signed [EW-1:0] s3_exact_ff [AXES];
   logic signed [EW-1:0] s3_dot_ff;

   rsp_item_type         s4_rsp_in;
   logic [PW-1:0]        s4_rad_in;
   logic                 s4_valid_ff;
   rsp_item_type         s4_rsp_ff;
   logic [PW-1:0]        s4_rad_ff;

   assign s4_ready = !s4_valid_ff || !out_stall;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_stall = !s1_ready;

   assign s1_a_in[0] = $signed(in_data.a_x[CW-1:0]);
   assign s1_a_in[1] = $signed(in_data.a_y[CW-1:0]);
   assign s1_a_in[2] = $signed(in_data.a_z[CW-1:0]);
   assign s1_b_in[0] = $signed(in_data.b_x[CW-1:0]);
   assign s1_b_in[1] = $signed(in_data.b_y[CW-1:0]);
   assign s1_b_in[2] = $signed(in_data.b_z[CW-1:0]);
   assign s1_f_in    = $signed(in_data.scale_factor[CW-1:0]);
   assign s1_op_in   = op_type'(in_data.req_type);
   assign s1_eq_in   = (s1_a_in[0] == s1_b_in[0]) && (s1_a_in[1] == s1_b_in[1]) &&
                       (s1_a_in[2] == s1_b_in[2]);

   always_comb begin
      for (int k = 0; k < MUL_LANES; k++) begin
         s1_ma_in[k] = '0;
         s1_mb_in[k] = '0;
      end
      unique case (s1_op_in)
         OP_SCALE: begin
            for (int k = 0; k < AXES; k++) begin
               s1_ma_in[k] = s1_a_in[k];
               s1_mb_in[k] = s1_f_in;
            end
         end
         OP_DOT: begin
            for (int k = 0; k < AXES; k++) begin
               s1_ma_in[k] = s1_a_in[k];
               s1_mb_in[k] = s1_b_in[k];
            end
         end
         OP_LENGTH: begin
            for (int k = 0; k < AXES; k++) begin
               s1_ma_in[k] = s1_a_in[k];
               s1_mb_in[k] = s1_a_in[k];
            end
         end
         OP_CROSS: begin
            s1_ma_in[0] = s1_a_in[1];
            s1_mb_in[0] = s1_b_in[2];
            s1_ma_in[1] = s1_a_in[2];
            s1_mb_in[1] = s1_b_in[1];
            s1_ma_in[2] = s1_a_in[2];
            s1_mb_in[2] = s1_b_in[0];
            s1_ma_in[3] = s1_a_in[0];
            s1_mb_in[3] = s1_b_in[2];
            s1_ma_in[4] = s1_a_in[0];
            s1_mb_in[4] = s1_b_in[1];
            s1_ma_in[5] = s1_a_in[1];
            s1_mb_in[5] = s1_b_in[0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < MUL_LANES; k++) begin
         s2_prod_in[k] = s1_ma_ff[k] * s1_mb_ff[k];
      end
      for (int k = 0; k < AXES; k++) begin
         s2_sum_in[k] = (s1_op_ff == OP_SUB) ? SW'(s1_a_ff[k]) - SW'(s1_b_ff[k])
                                             : SW'(s1_a_ff[k]) + SW'(s1_b_ff[k]);
      end
   end

   always_comb begin
      s3_dot_in = EW'(s2_prod_ff[0]) + EW'(s2_prod_ff[1]) + EW'(s2_prod_ff[2]);
      for (int k = 0; k < AXES; k++) begin
         s3_exact_in[k] = '0;
      end
      unique case (s2_op_ff)
         OP_ADD, OP_SUB: begin
            for (int k = 0; k < AXES; k++) begin
               s3_exact_in[k] = EW'(s2_sum_ff[k]);
            end
         end
         OP_SCALE: begin
            for (int k = 0; k < AXES; k++) begin
               s3_exact_in[k] = EW'(s2_prod_ff[k]);
            end
         end
         OP_CROSS: begin
            s3_exact_in[0] = EW'(s2_prod_ff[0]) - EW'(s2_prod_ff[1]);
            s3_exact_in[1] = EW'(s2_prod_ff[2]) - EW'(s2_prod_ff[3]);
            s3_exact_in[2] = EW'(s2_prod_ff[4]) - EW'(s2_prod_ff[5]);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      s4_rsp_in = '0;
      s4_rad_in = '0;
      unique case (s3_op_ff)
         OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
            s4_rsp_in.res_x         = wrap(s3_exact_ff[0]);
            s4_rsp_in.res_y         = wrap(s3_exact_ff[1]);
            s4_rsp_in.res_z         = wrap(s3_exact_ff[2]);
            s4_rsp_in.overflow_flag = !fits(s3_exact_ff[0]) || !fits(s3_exact_ff[1]) ||
                                      !fits(s3_exact_ff[2]);
         end
         OP_DOT: begin
            s4_rsp_in.dot_value     = wrap(s3_dot_ff);
            s4_rsp_in.overflow_flag = !fits(s3_dot_ff);
         end
         OP_EQUAL: begin
            s4_rsp_in.equal_flag = s3_eq_ff;
         end
         OP_LENGTH: begin
            s4_rad_in = s3_dot_ff[PW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_op_ff <= s1_op_in;
         s1_eq_ff <= s1_eq_in;
         s1_a_ff  <= s1_a_in;
         s1_b_ff  <= s1_b_in;
         s1_ma_ff <= s1_ma_in;
         s1_mb_ff <= s1_mb_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff   <= s1_op_ff;
         s2_eq_ff   <= s1_eq_ff;
         s2_prod_ff <= s2_prod_in;
         s2_sum_ff  <= s2_sum_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_op_ff    <= s2_op_ff;
         s3_eq_ff    <= s2_eq_ff;
         s3_exact_ff <= s3_exact_in;
         s3_dot_ff   <= s3_dot_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_rsp_ff <= s4_rsp_in;
         s4_rad_ff <= s4_rad_in;
      end
   end

   assign out_valid    = s4_valid_ff;
   assign out_data     = s4_rsp_ff;
   assign out_radicand = s4_rad_ff;

endmodule

`default_nettype wire

>>> hw/rtl/v3alu_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module v3alu_sqrt
   import v3alu_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_stall,
   input  wire rsp_item_type               in_data,
   input  wire logic [2*COORD_WIDTH-1:0]   in_radicand,
   output logic                            out_valid,
   input  wire logic                       out_stall,
   output rsp_item_type                    out_data
);

   localparam int CW     = COORD_WIDTH;
   localparam int STAGES = (CW + 1) / 2;
   localparam int ROOT_W = 2 * STAGES;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int LAST   = STAGES - 1;

   function automatic logic [REM_W+ROOT_W-1:0] root_step(
      input logic [REM_W-1:0]  rem,
      input logic [ROOT_W-1:0] root,
      input logic [1:0]        pair
   );
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      logic             ge;
      shifted = {rem[REM_W-3:0], pair};
      trial   = {root, 2'b01};
      ge      = shifted >= trial;
      return {ge ? shifted - trial : shifted, root[ROOT_W-2:0], ge};
   endfunction

   logic [STAGES:0]    ready;
   logic               valid_ff [STAGES];
   rsp_item_type       side_ff  [STAGES];
   logic [RAD_W-1:0]   rad_ff   [STAGES];
   logic [REM_W-1:0]   rem_ff   [STAGES];
   logic [ROOT_W-1:0]  root_ff  [STAGES];

   assign ready[STAGES] = !out_stall;
   assign in_stall      = !ready[0];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                     src_valid;
      rsp_item_type             src_side;
      logic [RAD_W-1:0]         src_rad;
      logic [REM_W-1:0]         src_rem;
      logic [ROOT_W-1:0]        src_root;
      logic [REM_W+ROOT_W-1:0]  step_a;
      logic [REM_W+ROOT_W-1:0]  step_b;
      logic [RAD_W-1:0]         rad_in;

      if (s == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_side  = in_data;
         assign src_rad   = RAD_W'(in_radicand);
         assign src_rem   = '0;
         assign src_root  = '0;
      end else begin : g_body
         assign src_valid = valid_ff[s-1];
         assign src_side  = side_ff[s-1];
         assign src_rad   = rad_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_root  = root_ff[s-1];
      end

      assign step_a = root_step(src_rem, src_root, src_rad[RAD_W-1 -: 2]);
      assign step_b = root_step(step_a[REM_W+ROOT_W-1 -: REM_W], step_a[ROOT_W-1:0],
                                src_rad[RAD_W-3 -: 2]);
      assign rad_in = src_rad << 4;

      assign ready[s] = !valid_ff[s] || ready[s+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= src_valid;
         end
         if (ready[s] && src_valid) begin
            side_ff[s] <= src_side;
            rad_ff[s]  <= rad_in;
            rem_ff[s]  <= step_b[REM_W+ROOT_W-1 -: REM_W];
            root_ff[s] <= step_b[ROOT_W-1:0];
         end
      end
   end

   assign out_valid = valid_ff[LAST];

   always_comb begin
      out_data              = side_ff[LAST];
      out_data.length_value = FIELD_WIDTH'(root_ff[LAST][CW-1:0]);
   end

   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_stall |=> valid_ff[0])
      else $error("accepted transfer did not enter the root pipeline");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && out_stall |=>
         valid_ff[LAST] && $stable(root_ff[LAST]) && $stable(side_ff[LAST]))
      else $error("stalled result changed");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !out_stall && !valid_ff[LAST-1] |=> !valid_ff[LAST])
      else $error("result repeated after transfer");

endmodule

`default_nettype wire

>>> hw/rtl/vector3_integer_alu.sv
// vector3_integer_alu: pipelined ALU on signed three-component integer vectors.
// Request channel (req_valid, req_stall, req_data): one transfer per operation,
// carrying the operation code, vectors A and B and the scale factor. Only the
// low COORD_WIDTH bits of each coordinate are used, read as two's complement.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one result per
// request, in request order. Fields that the operation does not produce are 0.
// Pipeline: operand select, multiply, combine and wrap stages, then a square root
// pipeline that resolves two root bits per stage for the magnitude.
// Throughput: one request per cycle while rsp_stall is low; every operation
// follows the same path.
// Stall: each stage holds while the stage after it is full and held, so empty
// stages close up; req_stall rises only when every stage is full and rsp_stall
// holds the response. A held response stays unchanged.
// Reset: synchronous, active high; clears all valid bits, dropping any work in
// flight. No clearing pass; requests are taken as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module vector3_integer_alu
   import v3alu_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_item_type  req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_item_type       rsp_data
);

   logic                       mid_valid;
   logic                       mid_stall;
   rsp_item_type               mid_data;
   logic [2*COORD_WIDTH-1:0]   mid_radicand;

   v3alu_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_data      (req_data),
      .out_valid    (mid_valid),
      .out_stall    (mid_stall),
      .out_data     (mid_data),
      .out_radicand (mid_radicand)
   );

   v3alu_sqrt #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_stall    (mid_stall),
      .in_data     (mid_data),
      .in_radicand (mid_radicand),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_data    (rsp_data)
   );

endmodule

`default_nettype wire

>>> sim/vector3_integer_alu_test.sv
`timescale 1ns / 1ps

module vector3_integer_alu_test;
   import v3alu_pkg::*;

   localparam int COORD_WIDTH = 32;
   localparam int RANDOM_OPS  = 1800;
   localparam int PAUSE_EVERY = 600;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 3'd7;

   localparam logic [31:0] MAXV = 32'h7fff_ffff;
   localparam logic [31:0] MINV = 32'h8000_0000;

   localparam logic signed [127:0] COORD_MAX = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
   localparam logic signed [127:0] COORD_MIN = -COORD_MAX - 128'sd1;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_LONG,
      STALL_LIGHT
   } stall_pattern_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   req_item_type pending_ops[$];
   bit           pause_marks[$];
   rsp_item_type awaited_results[$];
   rsp_item_type front_result;

   logic              req_taken;
   int                burst_left;
   int                gap_left;
   int                stall_left;
   int                pattern_left;
   stall_pattern_type stall_pattern;
   int                accepted_count;
   int                total_ops;
   int                errors;
   int                cycle_count;

   vector3_integer_alu dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic signed [127:0] coord_value(logic [31:0] raw);
      logic signed [31:0] t;
      t = raw <<< (32 - COORD_WIDTH);
      t = t >>> (32 - COORD_WIDTH);
      return t;
   endfunction

   function automatic logic [31:0] wrap_coord(logic signed [127:0] v);
      logic signed [31:0] t;
      t = v[31:0] <<< (32 - COORD_WIDTH);
      t = t >>> (32 - COORD_WIDTH);
      return t;
   endfunction

   function automatic logic out_of_range(logic signed [127:0] v);
      return (v > COORD_MAX) || (v < COORD_MIN);
   endfunction

   function automatic logic [31:0] floor_root(logic [63:0] n);
      logic [31:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         c = {32'b0, r | (32'd1 << i)};
         if (c * c <= n) begin
            r = c[31:0];
         end
      end
      return r;
   endfunction

   function automatic rsp_item_type alu_result(req_item_type req);
      rsp_item_type r;
      logic signed [127:0] ax, ay, az, bx, by, bz, f, ex, ey, ez, ed, sq;
      logic vec_op;
      r = '0;
      vec_op = 1'b0;
      ax = coord_value(req.a_x);
      ay = coord_value(req.a_y);
      az = coord_value(req.a_z);
      bx = coord_value(req.b_x);
      by = coord_value(req.b_y);
      bz = coord_value(req.b_z);
      f  = coord_value(req.scale_factor);
      ex = '0;
      ey = '0;
      ez = '0;
      case (req.req_type)
         OP_ADD: begin
            ex = ax + bx;
            ey = ay + by;
            ez = az + bz;
            vec_op = 1'b1;
         end
         OP_SUB: begin
            ex = ax - bx;
            ey = ay - by;
            ez = az - bz;
            vec_op = 1'b1;
         end
         OP_SCALE: begin
            ex = ax * f;
            ey = ay * f;
            ez = az * f;
            vec_op = 1'b1;
         end
         OP_CROSS: begin
            ex = ay * bz - az * by;
            ey = az * bx - ax * bz;
            ez = ax * by - ay * bx;
            vec_op = 1'b1;
         end
         OP_DOT: begin
            ed = ax * bx + ay * by + az * bz;
            r.dot_value = wrap_coord(ed);
            r.overflow_flag = out_of_range(ed);
         end
         OP_EQUAL: begin
            r.equal_flag = (ax == bx) && (ay == by) && (az == bz);
         end
         OP_LENGTH: begin
            sq = ax * ax + ay * ay + az * az;
            r.length_value = floor_root(sq[63:0]);
         end
         default: begin
         end
      endcase
      if (vec_op) begin
         r.res_x = wrap_coord(ex);
         r.res_y = wrap_coord(ey);
         r.res_z = wrap_coord(ez);
         r.overflow_flag = out_of_range(ex) || out_of_range(ey) || out_of_range(ez);
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: return MINV;
         1: return MAXV;
         2: return {{29{r[2]}}, r[2:0]};
         3, 4: return {{17{r[15]}}, r[14:0]};
         5: return {{8{r[23]}}, r[23:0]};
         default: return r;
      endcase
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7: return $urandom_range(1, 3);
         8: return $urandom_range(4, 10);
         default: return $urandom_range(20, 40);
      endcase
   endfunction

   task automatic queue_op(input logic [OP_WIDTH-1:0] op,
                           input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] az, input logic [31:0] bx,
                           input logic [31:0] by, input logic [31:0] bz,
                           input logic [31:0] f, input bit pause);
      req_item_type item;
      item.req_type     = op;
      item.a_x          = ax;
      item.a_y          = ay;
      item.a_z          = az;
      item.b_x          = bx;
      item.b_y          = by;
      item.b_z          = bz;
      item.scale_factor = f;
      pending_ops.push_back(item);
      pause_marks.push_back(pause);
   endtask

   task automatic check_field(input string label, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("mismatch %s: expected %h, got %h", label, want, got);
         end
      end
   endtask

   // request driver: bursts with random gaps, hold while stalled, pause at marked ops until results drain
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_ops.size() == 0 ||
                   (pause_marks[0] && awaited_results.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_data <= pending_ops.pop_front();
         pause_marks.delete(0);
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= pick_gap();
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         pattern_left <= $urandom_range(50, 300);
         stall_pattern <= stall_pattern_type'($urandom_range(0, 3));
      end else begin
         pattern_left <= pattern_left - 1;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         case (stall_pattern)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_COIN: rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_LONG: begin
               if ($urandom_range(0, 15) == 0) begin
                  rsp_stall <= 1'b1;
                  stall_left <= $urandom_range(3, 25);
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // transfer monitor and result check
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("unexpected result transfer: %h", rsp_data);
               end
            end else begin
               front_result = awaited_results.pop_front();
               check_field("res_x", rsp_data.res_x, front_result.res_x);
               check_field("res_y", rsp_data.res_y, front_result.res_y);
               check_field("res_z", rsp_data.res_z, front_result.res_z);
               check_field("dot_value", rsp_data.dot_value, front_result.dot_value);
               check_field("length_value", rsp_data.length_value,
                           front_result.length_value);
               check_field("equal_flag", {31'b0, rsp_data.equal_flag},
                           {31'b0, front_result.equal_flag});
               check_field("overflow_flag", {31'b0, rsp_data.overflow_flag},
                           {31'b0, front_result.overflow_flag});
            end
         end
         if (req_valid && !req_stall) begin
            awaited_results.push_back(alu_result(req_data));
            accepted_count <= accepted_count + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("vector3_integer_alu regression: fail");
         $finish;
      end
   end

   initial begin
      logic [OP_WIDTH-1:0] op;
      logic [31:0] ax, ay, az, bx, by, bz, f;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_left = 0;
      pattern_left = 0;
      stall_pattern = STALL_NONE;
      accepted_count = 0;
      errors = 0;
      cycle_count = 0;

      queue_op(OP_ADD, MAXV, MINV, MINV, MAXV, MINV, 32'hffff_ffff, 32'd0, 1'b0);
      queue_op(OP_ADD, 32'd5, 32'hffff_fffd, 32'd0, 32'd7, 32'd3, 32'd0, 32'd9, 1'b0);
      queue_op(OP_SUB, 32'd0, MAXV, MINV, MINV, MINV, 32'd1, 32'd0, 1'b0);
      queue_op(OP_SUB, 32'd10, 32'd20, 32'hffff_ffff, 32'd3, 32'd25, 32'd1, 32'd0, 1'b0);
      queue_op(OP_SCALE, MINV, MAXV, 32'd1, 32'd0, 32'd0, 32'd0, MINV, 1'b0);
      queue_op(OP_SCALE, MINV, 32'd3, 32'hffff_fff0, 32'd0, 32'd0, 32'd0,
               32'hffff_ffff, 1'b0);
      queue_op(OP_SCALE, MAXV, MINV, 32'd12, 32'd1, 32'd1, 32'd1, 32'd0, 1'b0);
      queue_op(OP_SCALE, 32'd1000, 32'hffff_fc18, 32'd7, 32'd0, 32'd0, 32'd0,
               32'd2000, 1'b0);
      queue_op(OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 32'd0, 1'b0);
      queue_op(OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 32'd0, 1'b0);
      queue_op(OP_DOT, 32'd2, 32'd3, 32'd4, 32'd5, 32'hffff_fffa, 32'd7, 32'd0, 1'b0);
      queue_op(OP_CROSS, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 1'b0);
      queue_op(OP_CROSS, MINV, MAXV, MINV, MAXV, MINV, MAXV, 32'd0, 1'b0);
      queue_op(OP_CROSS, 32'd3, 32'hffff_fffe, 32'd5, 32'd7, 32'd11, 32'hffff_fff3,
               32'd0, 1'b0);
      queue_op(OP_EQUAL, MINV, MAXV, 32'd0, MINV, MAXV, 32'd0, 32'd0, 1'b0);
      queue_op(OP_EQUAL, MINV, MAXV, 32'd0, MINV, MAXV, 32'd1, 32'd0, 1'b0);
      queue_op(OP_EQUAL, 32'd4, 32'd5, 32'd6, 32'd5, 32'd5, 32'd6, 32'd0, 1'b0);
      queue_op(OP_LENGTH, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, 1'b0);
      queue_op(OP_LENGTH, MAXV, MAXV, MAXV, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_op(OP_LENGTH, 32'd0, 32'd0, 32'd0, MINV, MINV, MINV, MINV, 1'b0);
      queue_op(OP_LENGTH, 32'd3, 32'hffff_fffc, 32'd12, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_op(OP_UNUSED, MAXV, MINV, 32'd5, MAXV, MINV, 32'd5, MAXV, 1'b0);
      queue_op(OP_UNUSED, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         if ($urandom_range(0, 15) == 0) begin
            op = OP_UNUSED;
         end else begin
            op = OP_WIDTH'($urandom_range(int'(OP_ADD), int'(OP_LENGTH)));
         end
         ax = pick_coord();
         ay = pick_coord();
         az = pick_coord();
         bx = pick_coord();
         by = pick_coord();
         bz = pick_coord();
         f = pick_coord();
         if (op == OP_EQUAL && $urandom_range(0, 3) != 0) begin
            bx = ax;
            by = ay;
            bz = az;
            case ($urandom_range(0, 5))
               0: bx = bx ^ (32'd1 << $urandom_range(0, 31));
               1: by = by ^ (32'd1 << $urandom_range(0, 31));
               2: bz = bz ^ (32'd1 << $urandom_range(0, 31));
               default: begin
               end
            endcase
         end
         queue_op(op, ax, ay, az, bx, by, bz, f, (n % PAUSE_EVERY) == 0);
      end
      total_ops = pending_ops.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count != total_ops) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("vector3_integer_alu regression: pass");
      end else begin
         $display("vector3_integer_alu regression: fail");
      end
      $finish;
   end

endmodule
